[design/kvs_pkg.sv]
// Package for the scoped key/value store: payload structs, sequencer states,
// constants and the IEEE equality helper. No dependencies.
package kvs_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
	localparam logic [31:0] POS_ZERO = 32'h0000_0000;
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_SET = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [31:0] key;
		logic [31:0] value;
	} kvs_cmd_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        is_set;
		logic        dropped;
	} kvs_rsp_t;

	typedef struct packed {
		logic key_hit;
		logic marker_hit;
		logic val_eq;
	} kvs_match_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_CHECK,
		ST_MISS,
		ST_APPEND,
		ST_DONE
	} kvs_state_t;

	function automatic logic is_nan(input logic [31:0] a);
		is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic ieee_eq(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ab;
		ab = a | b;
		if (is_nan(a) || is_nan(b)) begin
			ieee_eq = 1'b0;
		end else if (ab[30:0] == 31'd0) begin
			ieee_eq = 1'b1;
		end else begin
			ieee_eq = (a == b);
		end
	endfunction

endpackage

[design/kvs_mem.sv]
// Entry storage: key and value arrays, one write port and one registered read port.
// Depends on nothing outside this file.
module kvs_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wkey,
	input  logic [31:0]   wval,
	input  logic          wkey_en,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rkey,
	output logic [31:0]   rval
);

	logic [31:0] key_mem [DEPTH];
	logic [31:0] val_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			val_mem[waddr] <= wval;
			if (wkey_en) begin
				key_mem[waddr] <= wkey;
			end
		end
	end

	always_ff @(posedge clk) begin
		rkey <= key_mem[raddr];
		rval <= val_mem[raddr];
	end

endmodule

[design/kvs_match.sv]
// Compare unit: tests one table entry against the probe key, the
// scope marker and the new value. Uses kvs_pkg.
module kvs_match (
	input  logic [31:0]        entry_key,
	input  logic [31:0]        entry_val,
	input  logic [31:0]        probe_key,
	input  logic [31:0]        probe_val,
	input  logic [31:0]        marker,
	output kvs_pkg::kvs_match_t result
);
	import kvs_pkg::*;

	always_comb begin
		result.key_hit    = (entry_key == probe_key);
		result.marker_hit = (entry_key == marker);
		result.val_eq     = ieee_eq(entry_val, probe_val);
	end

endmodule

[design/scoped_key_value_store.sv]
// Scoped key/value store top level: sequencer, fill count, marker register.
// After START, a READ and a CHECK state per entry scanned on the registered read port,
// then MISS, APPEND or both as needed, then DONE; a marker set goes START, APPEND, DONE.
// Busy falls in the cycle after done; a new transfer is taken only once busy is low.
// Results strobe once on done; the receiver cannot stall.
// Reset clears fill count and marker register; entry storage is not cleared.
module scoped_key_value_store #(
	parameter int TABLE_DEPTH = kvs_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kvs_pkg::kvs_cmd_t cmd,
	output logic              done,
	output kvs_pkg::kvs_rsp_t rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data
);
	import kvs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	kvs_state_t  state_q, state_d;
	kvs_cmd_t    cmd_q;
	kvs_rsp_t    res_q, res_d;
	logic [31:0] marker_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] idx_q;
	logic        seen_q;

	logic [CW-1:0] fill_m1;
	logic        is_marker_set, table_full;
	logic        mem_we, mem_wkey_en;
	logic [AW-1:0] mem_waddr;
	logic [31:0] rkey, rval;
	kvs_match_t  m;
	logic        res_load, fill_inc, idx_load, idx_dec, seen_set, seen_clr;

	assign fill_m1       = fill_q - CW'(1);
	assign is_marker_set = (cmd_q.mode == MODE_SET) && (cmd_q.key == marker_q);
	assign table_full    = (fill_q >= CW'(TABLE_DEPTH));
	assign busy          = (state_q != ST_IDLE);
	assign done          = (state_q == ST_DONE);
	assign rsp           = res_q;
	assign cfg_ready     = 1'b1;

	kvs_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wkey    (cmd_q.key),
		.wval    (cmd_q.value),
		.wkey_en (mem_wkey_en),
		.raddr   (idx_q),
		.rkey    (rkey),
		.rval    (rval)
	);

	kvs_match u_match (
		.entry_key (rkey),
		.entry_val (rval),
		.probe_key (cmd_q.key),
		.probe_val (cmd_q.value),
		.marker    (marker_q),
		.result    (m)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_START;
			end
			ST_START: begin
				if (is_marker_set) state_d = ST_APPEND;
				else if (fill_q == CW'(0)) state_d = ST_MISS;
				else state_d = ST_READ;
			end
			ST_READ: state_d = ST_CHECK;
			ST_CHECK: begin
				if (m.key_hit) begin
					if (cmd_q.mode == MODE_GET || m.val_eq || !seen_q) state_d = ST_DONE;
					else state_d = ST_APPEND;
				end else if (idx_q == AW'(0)) begin
					state_d = ST_MISS;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_MISS: begin
				if (cmd_q.mode == MODE_GET || ieee_eq(NEG_ZERO, cmd_q.value)) state_d = ST_DONE;
				else state_d = ST_APPEND;
			end
			ST_APPEND: state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we      = 1'b0;
		mem_wkey_en = 1'b0;
		mem_waddr   = idx_q;
		res_d       = '0;
		res_load    = 1'b0;
		fill_inc    = 1'b0;
		idx_load    = 1'b0;
		idx_dec     = 1'b0;
		seen_set    = 1'b0;
		seen_clr    = 1'b0;
		unique case (state_q)
			ST_START: begin
				res_load = 1'b1;
				idx_load = 1'b1;
				seen_clr = 1'b1;
			end
			ST_CHECK: begin
				if (m.key_hit) begin
					if (cmd_q.mode == MODE_GET) begin
						res_d.read_value = rval;
						res_d.is_set     = !ieee_eq(rval, POS_ZERO);
						res_load         = 1'b1;
					end else if (!m.val_eq && !seen_q) begin
						mem_we = 1'b1;
					end
				end else begin
					idx_dec  = 1'b1;
					seen_set = m.marker_hit;
				end
			end
			ST_MISS: begin
				if (cmd_q.mode == MODE_GET) begin
					res_d.read_value = NEG_ZERO;
					res_d.is_set     = !ieee_eq(NEG_ZERO, POS_ZERO);
					res_load         = 1'b1;
				end
			end
			ST_APPEND: begin
				mem_waddr = fill_q[AW-1:0];
				if (table_full) begin
					res_d.dropped = 1'b1;
					res_load      = 1'b1;
				end else begin
					mem_we      = 1'b1;
					mem_wkey_en = 1'b1;
					fill_inc    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			marker_q <= '0;
			seen_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) marker_q <= cfg_data;
			if (fill_inc) fill_q <= fill_q + CW'(1);
			if (seen_clr) seen_q <= 1'b0;
			else if (seen_set) seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) cmd_q <= cmd;
		if (res_load) res_q <= res_d;
		if (idx_load) idx_q <= fill_m1[AW-1:0];
		else if (idx_dec) idx_q <= idx_q - AW'(1);
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
		else $error("fill count above table depth");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held more than one cycle");
	a_get_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done && cmd_q.mode == MODE_GET |-> !rsp.dropped)
		else $error("get reported a drop");
	a_set_zero_read: assert property (@(posedge clk) disable iff (!arst_n)
		done && cmd_q.mode == MODE_SET |-> rsp.read_value == POS_ZERO && !rsp.is_set)
		else $error("set returned a read value");
`endif

endmodule
